// ===== src/h1bf_pkg.sv =====
// shared codes and types for the http/1 body framing selector
package h1bf_pkg;

    typedef enum logic [2:0] {
        FR_NONE    = 3'd0,
        FR_FIXED   = 3'd1,
        FR_CHUNKED = 3'd2,
        FR_CLOSE   = 3'd3,
        FR_OPAQUE  = 3'd4
    } t_framing;

    typedef enum logic [2:0] {
        ST_CHUNK_LINE = 3'd0,
        ST_FIXED_BODY = 3'd1,
        ST_COMPLETE   = 3'd2,
        ST_CLOSE_BODY = 3'd3,
        ST_OPAQUE     = 3'd4,
        ST_FAILED     = 3'd5
    } t_body_state;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_LIMIT     = 2'd1,
        ERR_AMBIGUOUS = 2'd2,
        ERR_CODING    = 2'd3
    } t_error;

    typedef enum logic [1:0] {
        CODING_NONE    = 2'd0,
        CODING_CHUNKED = 2'd1,
        CODING_OTHER   = 2'd2
    } t_coding;

    typedef enum logic [1:0] {
        METHOD_OTHER   = 2'd0,
        METHOD_HEAD    = 2'd1,
        METHOD_CONNECT = 2'd2
    } t_method;

    localparam logic [9:0] STATUS_INFO_LO     = 10'd100;
    localparam logic [9:0] STATUS_INFO_HI     = 10'd199;
    localparam logic [9:0] STATUS_SWITCHING   = 10'd101;
    localparam logic [9:0] STATUS_SUCCESS_LO  = 10'd200;
    localparam logic [9:0] STATUS_SUCCESS_HI  = 10'd299;
    localparam logic [9:0] STATUS_NO_CONTENT  = 10'd204;
    localparam logic [9:0] STATUS_NOT_MODIFY  = 10'd304;

endpackage

// ===== src/http1_body_framing_select.sv =====
// top level of the http/1 body framing selector
//
// usage
//   input channel: one request per header summary (i_valid / o_stall);
//   a request is taken at a rising edge with i_valid high and o_stall low
//   output channel: one result request per input (o_valid / i_stall);
//   taken at a rising edge with o_valid high and i_stall low
//   config channel: i_cfg_valid / o_cfg_ready write max_body_length;
//   ready is always high, write only while the block is idle
// timing
//   two register stages: an input register, then the decision logic,
//   then the result register; a result moves from the input register
//   into the result register once that register is free
//   throughput is one request per cycle while i_stall is low, set by the
//   two-stage pipeline with no kept state between requests
// reset (synchronous, active low)
//   both stages empty, max_body_length back to all ones
// stall
//   when i_stall holds a full result register, the input stage holds
//   too and o_stall rises once that stage is also full; nothing is lost
module http1_body_framing_select #(
    parameter int LENGTH_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_is_response,
    input  logic                   i_version,
    input  logic                   i_framing_malformed,
    input  logic                   i_has_content_length,
    input  logic [LENGTH_BITS-1:0] i_content_length,
    input  logic [1:0]             i_transfer_coding,
    input  logic [9:0]             i_status_code,
    input  logic [1:0]             i_request_method,
    // output channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [2:0]             o_framing,
    output logic [2:0]             o_next_state,
    output logic [LENGTH_BITS-1:0] o_body_remaining,
    output logic [1:0]             o_error,
    // config channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LENGTH_BITS-1:0] i_cfg_data
);

    // config register
    logic [LENGTH_BITS-1:0] r_max_body_length;

    // input stage
    logic                   r_s1_valid;
    logic                   r_is_response;
    logic                   r_version;
    logic                   r_malformed;
    logic                   r_has_len;
    logic [LENGTH_BITS-1:0] r_len;
    logic [1:0]             r_coding;
    logic [9:0]             r_status;
    logic [1:0]             r_method;

    // result stage
    logic                   r_out_valid;
    logic [2:0]             r_framing;
    logic [2:0]             r_next_state;
    logic [LENGTH_BITS-1:0] r_remaining;
    logic [1:0]             r_error;

    logic                   n_out_valid;
    logic [2:0]             n_framing;
    logic [2:0]             n_next_state;
    logic [LENGTH_BITS-1:0] n_remaining;
    logic [1:0]             n_error;

    logic out_free;
    logic s1_free;

    // decision terms
    logic coding_present;
    logic coding_bad;
    logic over_limit;
    logic info;
    logic success;
    logic no_content;
    logic not_modified;
    logic is_head;
    logic is_connect;

    // handshake: result register frees when empty or taken
    assign out_free    = !r_out_valid || !i_stall;
    assign s1_free     = !r_s1_valid || out_free;
    assign o_stall     = !s1_free;
    assign o_cfg_ready = 1'b1;
    assign n_out_valid = r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body_length <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_body_length <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_is_response <= i_is_response;
            r_version     <= i_version;
            r_malformed   <= i_framing_malformed;
            r_has_len     <= i_has_content_length;
            r_len         <= i_content_length;
            r_coding      <= i_transfer_coding;
            r_status      <= i_status_code;
            r_method      <= i_request_method;
        end
    end

    // classification of the held request
    assign coding_present = r_coding != h1bf_pkg::CODING_NONE;
    // anything but chunked, and chunked under http/1.0, is unsupported
    assign coding_bad     = coding_present
                            && (!r_version || r_coding != h1bf_pkg::CODING_CHUNKED);
    assign over_limit     = r_has_len && (r_len > r_max_body_length);
    assign info           = r_status >= h1bf_pkg::STATUS_INFO_LO
                            && r_status <= h1bf_pkg::STATUS_INFO_HI;
    assign success        = r_status >= h1bf_pkg::STATUS_SUCCESS_LO
                            && r_status <= h1bf_pkg::STATUS_SUCCESS_HI;
    assign no_content     = r_status == h1bf_pkg::STATUS_NO_CONTENT;
    assign not_modified   = r_status == h1bf_pkg::STATUS_NOT_MODIFY;
    assign is_head        = r_method == h1bf_pkg::METHOD_HEAD;
    assign is_connect     = r_method == h1bf_pkg::METHOD_CONNECT;

    // decision chain, checks in priority order
    always_comb begin
        n_framing    = h1bf_pkg::FR_NONE;
        n_next_state = h1bf_pkg::ST_FAILED;
        n_remaining  = '0;
        n_error      = h1bf_pkg::ERR_NONE;
        if (r_malformed) begin
            n_error = h1bf_pkg::ERR_AMBIGUOUS;
        end else if (over_limit) begin
            n_error = h1bf_pkg::ERR_LIMIT;
        end else if (r_has_len && coding_present) begin
            // content-length together with transfer-encoding
            n_error = h1bf_pkg::ERR_AMBIGUOUS;
        end else if (r_is_response
                     && (r_status == h1bf_pkg::STATUS_SWITCHING
                         || (is_connect && success))) begin
            // protocol switch or tunnel: the rest of the stream is opaque
            n_framing    = h1bf_pkg::FR_OPAQUE;
            n_next_state = h1bf_pkg::ST_OPAQUE;
        end else if (r_is_response && (coding_present || r_has_len)
                     && (info || no_content)) begin
            // bodiless status that still declares a body
            n_error = h1bf_pkg::ERR_AMBIGUOUS;
        end else if (r_is_response && (is_head || info || no_content || not_modified)) begin
            n_next_state = h1bf_pkg::ST_COMPLETE;
        end else if (coding_present) begin
            if (coding_bad) begin
                n_error = h1bf_pkg::ERR_CODING;
            end else begin
                n_framing    = h1bf_pkg::FR_CHUNKED;
                n_next_state = h1bf_pkg::ST_CHUNK_LINE;
            end
        end else if (r_has_len) begin
            n_framing    = h1bf_pkg::FR_FIXED;
            n_next_state = (r_len == '0) ? h1bf_pkg::ST_COMPLETE
                                         : h1bf_pkg::ST_FIXED_BODY;
            n_remaining  = r_len;
        end else if (r_is_response) begin
            // no length given: response body runs to connection close
            n_framing    = h1bf_pkg::FR_CLOSE;
            n_next_state = h1bf_pkg::ST_CLOSE_BODY;
        end else begin
            // request without length has no body
            n_next_state = h1bf_pkg::ST_COMPLETE;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_framing    <= n_framing;
            r_next_state <= n_next_state;
            r_remaining  <= n_remaining;
            r_error      <= n_error;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_framing        = r_framing;
    assign o_next_state     = r_next_state;
    assign o_body_remaining = r_remaining;
    assign o_error          = r_error;

`ifndef SYNTH
    // a failed result carries no framing and no length
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_next_state == h1bf_pkg::ST_FAILED
        |-> o_framing == h1bf_pkg::FR_NONE && o_body_remaining == '0)
        else $error("failed result with framing or length");

    // an error code is present exactly when the result is a failure
    a_err_iff_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_error != h1bf_pkg::ERR_NONE)
                     == (o_next_state == h1bf_pkg::ST_FAILED)))
        else $error("error code and failed state disagree");

    // fixed framing completes at once only for a zero length
    a_fixed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_framing == h1bf_pkg::FR_FIXED
        |-> ((o_body_remaining == '0) == (o_next_state == h1bf_pkg::ST_COMPLETE)))
        else $error("fixed framing length and state disagree");

    // upstream is held back only when both stages are full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule

// ===== bench/tb_http1_body_framing_select.sv =====
// self-checking bench for the http/1 body framing selector, with predictor and scoreboard
module tb_http1_body_framing_select;

    import h1bf_pkg::*;

    localparam int LEN_W = 48;
    // longest run we tolerate before calling it a hang
    localparam int unsigned CYCLE_LIMIT = 200000;
    // cycles to let the pipeline settle after the last expected result
    localparam int DRAIN_CYCLES = 6;
    // receiver hold-off that backs the pipeline up into the input
    localparam int HOLDOFF_CYCLES = 400;

    // codes outside the named ones, still legal on the 2-bit fields
    localparam logic [1:0] CODING_RESERVED = 2'd3;
    localparam logic [1:0] METHOD_RESERVED = 2'd3;

    // one parsed header summary as the block sees it
    typedef struct packed {
        logic             is_response;
        logic             version;
        logic             malformed;
        logic             has_len;
        logic [LEN_W-1:0] len;
        logic [1:0]       coding;
        logic [9:0]       status;
        logic [1:0]       method;
    } t_header_summary;

    // one framing decision
    typedef struct packed {
        t_framing         framing;
        t_body_state      state;
        logic [LEN_W-1:0] remaining;
        t_error           err;
    } t_body_decision;

    // predicts the framing of each accepted header and checks results in order
    class framing_scoreboard;
        logic [LEN_W-1:0] body_limit;
        t_body_decision   decision_q[$];
        int unsigned      fail_count;

        function new();
            body_limit = '1;
            fail_count = 0;
        endfunction

        function t_body_decision decision(t_framing f, t_body_state s,
                                          logic [LEN_W-1:0] r, t_error e);
            t_body_decision d;
            d.framing   = f;
            d.state     = s;
            d.remaining = r;
            d.err       = e;
            return d;
        endfunction

        // chunked, fixed length, or the fallback when no length is known
        function t_body_decision coded_body(t_header_summary h, t_framing fb_framing,
                                            t_body_state fb_state);
            if (h.coding != CODING_NONE) begin
                // only chunked under http/1.1 is supported; the reserved code counts as other
                if (!h.version || h.coding != CODING_CHUNKED)
                    return decision(FR_NONE, ST_FAILED, '0, ERR_CODING);
                return decision(FR_CHUNKED, ST_CHUNK_LINE, '0, ERR_NONE);
            end
            if (h.has_len)
                return decision(FR_FIXED, (h.len == '0) ? ST_COMPLETE : ST_FIXED_BODY,
                                h.len, ERR_NONE);
            return decision(fb_framing, fb_state, '0, ERR_NONE);
        endfunction

        function t_body_decision decide(t_header_summary h);
            logic info, success, no_content, not_modified;
            info         = h.status >= STATUS_INFO_LO && h.status <= STATUS_INFO_HI;
            success      = h.status >= STATUS_SUCCESS_LO && h.status <= STATUS_SUCCESS_HI;
            no_content   = h.status == STATUS_NO_CONTENT;
            not_modified = h.status == STATUS_NOT_MODIFY;
            if (h.malformed)
                return decision(FR_NONE, ST_FAILED, '0, ERR_AMBIGUOUS);
            if (h.has_len && h.len > body_limit)
                return decision(FR_NONE, ST_FAILED, '0, ERR_LIMIT);
            if (h.has_len && h.coding != CODING_NONE)
                return decision(FR_NONE, ST_FAILED, '0, ERR_AMBIGUOUS);
            if (!h.is_response)
                return coded_body(h, FR_NONE, ST_COMPLETE);
            // status outside 100..599 falls through as an ordinary final status
            if (h.status == STATUS_SWITCHING || (h.method == METHOD_CONNECT && success))
                return decision(FR_OPAQUE, ST_OPAQUE, '0, ERR_NONE);
            if ((h.coding != CODING_NONE || h.has_len) && (info || no_content))
                return decision(FR_NONE, ST_FAILED, '0, ERR_AMBIGUOUS);
            if (h.method == METHOD_HEAD || info || no_content || not_modified)
                return decision(FR_NONE, ST_COMPLETE, '0, ERR_NONE);
            return coded_body(h, FR_CLOSE, ST_CLOSE_BODY);
        endfunction

        function void note_request(t_header_summary h);
            decision_q.push_back(decide(h));
        endfunction

        function int pending();
            return decision_q.size();
        endfunction

        function void check_result(t_body_decision got);
            t_body_decision want;
            if (decision_q.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result: framing=%0d state=%0d remaining=%0d err=%0d",
                             got.framing, got.state, got.remaining, got.err);
                fail_count++;
                return;
            end
            want = decision_q.pop_front();
            if (got.framing != want.framing || got.state != want.state ||
                got.remaining != want.remaining || got.err != want.err) begin
                if (fail_count < 10) begin
                    $display("mismatch: expected framing=%0d state=%0d remaining=%0d err=%0d",
                             want.framing, want.state, want.remaining, want.err);
                    $display("          got framing=%0d state=%0d remaining=%0d err=%0d",
                             got.framing, got.state, got.remaining, got.err);
                end
                fail_count++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic             i_is_response;
    logic             i_version;
    logic             i_framing_malformed;
    logic             i_has_content_length;
    logic [LEN_W-1:0] i_content_length;
    logic [1:0]       i_transfer_coding;
    logic [9:0]       i_status_code;
    logic [1:0]       i_request_method;
    logic             o_valid;
    logic             i_stall;
    logic [2:0]       o_framing;
    logic [2:0]       o_next_state;
    logic [LEN_W-1:0] o_body_remaining;
    logic [1:0]       o_error;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [LEN_W-1:0] i_cfg_data;

    framing_scoreboard sb = new();

    // idle chance in percent, shared by sender and receiver
    int          idle_pct;
    // set by the stimulus to ask the receiver for a long hold-off
    bit          holdoff_request;
    int          holdoff_left;
    int unsigned cycle_count;

    http1_body_framing_select #(
        .LENGTH_BITS(LEN_W)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_is_response        (i_is_response),
        .i_version            (i_version),
        .i_framing_malformed  (i_framing_malformed),
        .i_has_content_length (i_has_content_length),
        .i_content_length     (i_content_length),
        .i_transfer_coding    (i_transfer_coding),
        .i_status_code        (i_status_code),
        .i_request_method     (i_request_method),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_framing            (o_framing),
        .o_next_state         (o_next_state),
        .o_body_remaining     (o_body_remaining),
        .o_error              (o_error),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_http1_body_framing_select: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request so the
    // pipeline fills and the input side has to stall
    initial begin
        i_stall      = 1'b0;
        holdoff_left = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_request) begin
                holdoff_request = 1'b0;
                holdoff_left    = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                i_stall = 1'b1;
                holdoff_left--;
            end else begin
                i_stall = ($urandom_range(99) < idle_pct);
            end
        end
    end

    // result monitor: every accepted result goes against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_body_decision got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.framing   = t_framing'(o_framing);
            got.state     = t_body_state'(o_next_state);
            got.remaining = o_body_remaining;
            got.err       = t_error'(o_error);
            sb.check_result(got);
        end
    end

    function automatic t_header_summary hdr(int resp, int ver, int malf, int hl,
                                            logic [LEN_W-1:0] len, logic [1:0] cod,
                                            logic [9:0] st, logic [1:0] m);
        t_header_summary h;
        h.is_response = 1'(resp);
        h.version     = 1'(ver);
        h.malformed   = 1'(malf);
        h.has_len     = 1'(hl);
        h.len         = len;
        h.coding      = cod;
        h.status      = st;
        h.method      = m;
        return h;
    endfunction

    // mostly well-formed headers; lengths cluster around the current limit
    function automatic t_header_summary rand_header(logic [LEN_W-1:0] limit);
        t_header_summary h;
        logic [9:0] picks [10] = '{STATUS_INFO_LO, STATUS_SWITCHING, STATUS_INFO_HI,
                                   STATUS_SUCCESS_LO, STATUS_NO_CONTENT,
                                   STATUS_SUCCESS_HI, STATUS_NOT_MODIFY,
                                   10'd404, 10'd500, 10'd599};
        int r;
        h.is_response = 1'($urandom_range(1));
        h.version     = 1'($urandom_range(1));
        h.malformed   = ($urandom_range(99) < 8);
        h.has_len     = 1'($urandom_range(1));
        case ($urandom_range(7))
            0:       h.len = '0;
            1:       h.len = 48'd1;
            2:       h.len = limit - 48'd1;
            3:       h.len = limit;
            4:       h.len = limit + 48'd1;
            5:       h.len = 48'($urandom_range(65535));
            default: h.len = {16'($urandom), 32'($urandom)};
        endcase
        r = $urandom_range(9);
        if (r < 5)       h.coding = CODING_NONE;
        else if (r < 8)  h.coding = CODING_CHUNKED;
        else if (r == 8) h.coding = CODING_OTHER;
        else             h.coding = CODING_RESERVED;
        r = $urandom_range(99);
        if (r < 60)      h.status = picks[$urandom_range(9)];
        else if (r < 85) h.status = 10'($urandom_range(599, 100));
        else             h.status = 10'($urandom_range(1023));
        h.method = 2'($urandom_range(3));
        return h;
    endfunction

    // offer one request, starting at a falling edge; returns at a falling edge
    task automatic push_header(t_header_summary h);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_is_response        = h.is_response;
        i_version            = h.version;
        i_framing_malformed  = h.malformed;
        i_has_content_length = h.has_len;
        i_content_length     = h.len;
        i_transfer_coding    = h.coding;
        i_status_code        = h.status;
        i_request_method     = h.method;
        i_valid              = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(h);
        @(negedge i_clk);
    endtask

    // wait until every predicted result is back, then let the pipe settle
    task automatic drain();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_body_limit(logic [LEN_W-1:0] limit);
        i_cfg_valid = 1'b1;
        i_cfg_data  = limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.body_limit = limit;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_phase(logic [LEN_W-1:0] limit, int count, int pct, bit holdoff);
        drain();
        write_body_limit(limit);
        idle_pct = pct;
        if (holdoff)
            holdoff_request = 1'b1;
        repeat (count) push_header(rand_header(limit));
        i_valid = 1'b0;
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_is_response        = 1'b0;
        i_version            = 1'b0;
        i_framing_malformed  = 1'b0;
        i_has_content_length = 1'b0;
        i_content_length     = '0;
        i_transfer_coding    = CODING_NONE;
        i_status_code        = STATUS_SUCCESS_LO;
        i_request_method     = METHOD_OTHER;
        i_cfg_valid          = 1'b0;
        i_cfg_data           = '0;
        idle_pct             = 7;
        holdoff_request      = 1'b0;
        cycle_count          = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed headers at the reset limit (all ones)
        // requests: malformed wins over everything, lengths at both ends, codings
        push_header(hdr(0, 1, 1, 0, '0, CODING_NONE, STATUS_SUCCESS_LO, METHOD_OTHER));
        push_header(hdr(0, 1, 1, 1, '1, CODING_CHUNKED, STATUS_SUCCESS_LO, METHOD_OTHER));
        push_header(hdr(0, 1, 0, 1, '0, CODING_NONE, STATUS_SUCCESS_LO, METHOD_OTHER));
        push_header(hdr(0, 0, 0, 1, '1, CODING_NONE, STATUS_SUCCESS_LO, METHOD_OTHER));
        push_header(hdr(0, 1, 0, 0, '0, CODING_NONE, STATUS_SUCCESS_LO, METHOD_OTHER));
        push_header(hdr(0, 1, 0, 0, '0, CODING_CHUNKED, STATUS_SUCCESS_LO, METHOD_OTHER));
        push_header(hdr(0, 0, 0, 0, '0, CODING_CHUNKED, STATUS_SUCCESS_LO, METHOD_OTHER));
        push_header(hdr(0, 1, 0, 0, '0, CODING_OTHER, STATUS_SUCCESS_LO, METHOD_OTHER));
        // reserved coding counts as an unsupported coding
        push_header(hdr(0, 1, 0, 0, '0, CODING_RESERVED, STATUS_SUCCESS_LO, METHOD_OTHER));
        // content-length together with transfer-encoding
        push_header(hdr(0, 1, 0, 1, 48'd10, CODING_CHUNKED, STATUS_SUCCESS_LO,
                        METHOD_OTHER));
        // responses: switching protocols and connect tunnels
        push_header(hdr(1, 1, 0, 1, 48'd7, CODING_NONE, STATUS_SWITCHING, METHOD_OTHER));
        push_header(hdr(1, 1, 0, 0, '0, CODING_NONE, STATUS_SUCCESS_LO, METHOD_CONNECT));
        push_header(hdr(1, 1, 0, 0, '0, CODING_NONE, 10'd404, METHOD_CONNECT));
        // informational and no-content with a body declared
        push_header(hdr(1, 1, 0, 1, 48'd3, CODING_NONE, STATUS_INFO_LO, METHOD_OTHER));
        push_header(hdr(1, 1, 0, 0, '0, CODING_CHUNKED, STATUS_NO_CONTENT, METHOD_OTHER));
        // bodiless responses
        push_header(hdr(1, 1, 0, 0, '0, CODING_NONE, STATUS_NO_CONTENT, METHOD_OTHER));
        push_header(hdr(1, 1, 0, 1, 48'd99, CODING_NONE, STATUS_NOT_MODIFY, METHOD_OTHER));
        push_header(hdr(1, 1, 0, 1, 48'd99, CODING_NONE, STATUS_SUCCESS_LO, METHOD_HEAD));
        push_header(hdr(1, 1, 0, 0, '0, CODING_CHUNKED, STATUS_INFO_HI, METHOD_HEAD));
        // bodies: close delimited, fixed, chunked
        push_header(hdr(1, 0, 0, 0, '0, CODING_NONE, STATUS_SUCCESS_LO, METHOD_OTHER));
        push_header(hdr(1, 1, 0, 1, 48'd5, CODING_NONE, STATUS_SUCCESS_HI, METHOD_OTHER));
        push_header(hdr(1, 1, 0, 0, '0, CODING_CHUNKED, 10'd599, METHOD_OTHER));
        push_header(hdr(1, 0, 0, 0, '0, CODING_CHUNKED, 10'd500, METHOD_OTHER));
        // status outside the defined range is an ordinary final status
        push_header(hdr(1, 1, 0, 0, '0, CODING_NONE, 10'd0, METHOD_OTHER));
        push_header(hdr(1, 1, 0, 1, '1, CODING_NONE, 10'd1023, METHOD_RESERVED));
        i_valid = 1'b0;

        // random phases over several limits, the extremes among them;
        // the first asks for the long receiver hold-off, the fourth never idles
        run_phase('1, 500, 7, 1'b1);
        run_phase('0, 300, 7, 1'b0);
        run_phase({16'($urandom), 32'($urandom)}, 300, 7, 1'b0);
        run_phase(48'd1000, 300, 0, 1'b0);
        run_phase(48'h0000_FFFF_FFFF, 250, 7, 1'b0);
        run_phase('1, 250, 7, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("tb_http1_body_framing_select: PASS");
        end else begin
            $display("tb_http1_body_framing_select: FAIL");
        end
        $finish;
    end

endmodule
